// ===== hw/rtl/spgf_pkg.sv =====
// Package of the segmented peak gradient fill: transaction structs, handshake
// structs between the sequencer and its helper units, and fixed constants.
// No dependencies.
package spgf_pkg;

    // Input transaction: one rectangle request.
    typedef struct packed {
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic signed [15:0] rect_w;
        logic signed [15:0] rect_h;
        logic signed [19:0] peak_pos;
        logic signed [15:0] band_start;
        logic signed [15:0] band_end;
    } t_in;

    // Output transaction: one segment.
    typedef struct packed {
        logic signed [16:0] seg_x;
        logic signed [15:0] seg_y;
        logic        [15:0] seg_width;
        logic        [14:0] seg_height;
        logic        [31:0] seg_color;
        logic               last_segment;
    } t_out;

    // Serial divider: widths and step count.
    localparam int DIV_STEPS = 16;
    localparam int DVD_W     = 16;
    localparam int DIVR_W    = 20;

    typedef struct packed {
        logic              start;
        logic [DIVR_W-1:0] rem_init;
        logic [DVD_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DVD_W-1:0]  quot;
        logic [DIVR_W-1:0] rem;
    } t_div_rsp;

    // Quality and fraction, 16 fraction bits.
    localparam int Q_W = 17;
    localparam int F_W = 16;
    localparam logic [Q_W-1:0] Q_ONE = 17'h1_0000;

    typedef struct packed {
        logic           start;
        logic [Q_W-1:0] q;
    } t_mix_req;

    typedef struct packed {
        logic        done;
        logic [31:0] color;
    } t_mix_rsp;

    // Reciprocals for constant division: ceil by six on small widths and
    // the rounded 0.70 scaling (divide by ten).
    localparam int RECIP_SIX       = 683;
    localparam int RECIP_SIX_SHIFT = 12;
    localparam int RECIP_TEN       = 838861;
    localparam int RECIP_TEN_SHIFT = 23;
    localparam int SEG_PIX         = 6;

    // Configuration registers.
    localparam int APB_AW = 3;
    localparam logic REG_EDGE = 1'b0;
    localparam logic REG_PEAK = 1'b1;
    localparam logic [31:0] COLOR_RESET = 32'hFFFF_FFFF;

endpackage

// ===== hw/rtl/spgf_div.sv =====
// Shared restoring divider of the gradient fill, one quotient bit per cycle.
// Depends on spgf_pkg.
module spgf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spgf_pkg::t_div_req i_req,
    output spgf_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(spgf_pkg::DIV_STEPS);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [spgf_pkg::DIVR_W-1:0]   r_rem;
    logic [spgf_pkg::DVD_W-1:0]    r_dvd;
    logic [spgf_pkg::DVD_W-1:0]    r_quot;
    logic [spgf_pkg::DIVR_W-1:0]   r_divisor;

    logic [spgf_pkg::DIVR_W:0]     trial;
    logic                          fits;
    logic [spgf_pkg::DIVR_W-1:0]   n_rem;

    // Shift the next dividend bit in and subtract where the divisor fits.
    assign trial = {r_rem, r_dvd[spgf_pkg::DVD_W-1]};
    assign fits  = trial >= {1'b0, r_divisor};
    assign n_rem = fits ? spgf_pkg::DIVR_W'(trial - {1'b0, r_divisor})
                        : trial[spgf_pkg::DIVR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(spgf_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= i_req.rem_init;
            r_dvd     <= i_req.dividend;
            r_divisor <= i_req.divisor;
            r_quot    <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_dvd  <= {r_dvd[spgf_pkg::DVD_W-2:0], 1'b0};
            r_quot <= {r_quot[spgf_pkg::DVD_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== hw/rtl/spgf_mix.sv =====
// Colour mixer of the gradient fill: scales the quality by 0.70 and blends
// the four colour bytes one per cycle through a single multiplier.
// Depends on spgf_pkg.
module spgf_mix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spgf_pkg::t_mix_req i_req,
    input  logic [31:0]        i_rim_colour,
    input  logic [31:0]        i_apex_colour,
    output spgf_pkg::t_mix_rsp o_rsp
);

    logic                     r_busy;
    logic                     r_done;
    logic [1:0]               r_k;
    logic [spgf_pkg::F_W-1:0] r_f;
    logic [31:0]              r_color;

    logic [19:0]        scaled;
    logic [38:0]        f_prod;
    logic [7:0]         byte_a;
    logic [7:0]         byte_b;
    logic signed [8:0]  diff;
    logic signed [25:0] blend;
    logic signed [25:0] mixed;

    // f = floor((7q + 5) / 10), done as a multiply by a scaled reciprocal.
    assign scaled = 20'(i_req.q) * 20'd7 + 20'd5;
    assign f_prod = 39'(scaled) * 39'(spgf_pkg::RECIP_TEN);

    assign byte_a = i_rim_colour[8*r_k +: 8];
    assign byte_b = i_apex_colour[8*r_k +: 8];
    assign diff   = $signed({1'b0, byte_b}) - $signed({1'b0, byte_a});
    assign blend  = diff * $signed({1'b0, r_f});
    assign mixed  = $signed({2'b00, byte_a, 16'h0000}) + blend + 26'sd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_f <= f_prod[spgf_pkg::RECIP_TEN_SHIFT +: spgf_pkg::F_W];
        end else if (r_busy) begin
            r_color <= {mixed[23:16], r_color[31:8]};
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.color = r_color;

endmodule

// ===== hw/rtl/spgf_apb.sv =====
// Configuration registers of the gradient fill behind an APB-style port:
// edge colour and peak colour. Depends on spgf_pkg.
module spgf_apb (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spgf_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [31:0]                 o_rim_colour,
    output logic [31:0]                 o_apex_colour
);

    logic [31:0] r_rim_colour;
    logic [31:0] r_apex_colour;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rim_colour  <= spgf_pkg::COLOR_RESET;
            r_apex_colour <= spgf_pkg::COLOR_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                spgf_pkg::REG_EDGE: r_rim_colour  <= pwdata;
                spgf_pkg::REG_PEAK: r_apex_colour <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            spgf_pkg::REG_EDGE: prdata = r_rim_colour;
            spgf_pkg::REG_PEAK: prdata = r_apex_colour;
            default:            prdata = '0;
        endcase
    end

    assign o_rim_colour  = r_rim_colour;
    assign o_apex_colour = r_apex_colour;

endmodule

// ===== hw/rtl/segmented_peak_gradient_fill.sv =====
// Segmented peak gradient fill. Each input transaction describes one
// rectangle; the block cuts its width into ceil(w/6) vertical segments (at
// most MAX_SEGMENTS and never more than the width) and sends one output
// transaction per segment, the final one marked with last_segment. A negative
// width extends leftwards; a zero width or a height of zero or less produces
// no output at all. Each segment's colour blends the edge colour towards the
// peak colour by 0.70 times a triangular quality of the segment midpoint
// against the peak, which is clamped into the band. One rectangle is worked
// on at a time and the input is stalled until its last segment has been
// taken. Setup is dominated by one pass of the serial divider to split the
// width evenly. Each segment then passes through the boundary, quality and
// mixer steps, with a pass of the divider added when the quality needs a
// true division, plus any output stall; the shared divider retires one
// quotient bit per cycle, and the mixer blends one colour byte per cycle.
module segmented_peak_gradient_fill #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  spgf_pkg::t_in               i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output spgf_pkg::t_out              o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spgf_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    // Width of a segment count or index; the count can equal MAX_SEGMENTS.
    localparam int N_W     = $clog2(MAX_SEGMENTS + 1);
    // Widths above this always give the full number of segments.
    localparam int SEG_LIM = spgf_pkg::SEG_PIX * (MAX_SEGMENTS - 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PREP   = 4'd1;
    localparam logic [3:0] ST_WSTART = 4'd2;
    localparam logic [3:0] ST_DIVW   = 4'd3;
    localparam logic [3:0] ST_SEGA   = 4'd4;
    localparam logic [3:0] ST_SEGB   = 4'd5;
    localparam logic [3:0] ST_SEGC   = 4'd6;
    localparam logic [3:0] ST_DIVQ   = 4'd7;
    localparam logic [3:0] ST_MIXS   = 4'd8;
    localparam logic [3:0] ST_MIX    = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    logic [3:0] r_state;

    // Captured request and per-rectangle values.
    spgf_pkg::t_in       r_req;
    logic signed [16:0]  r_x;
    logic [15:0]         r_y;
    logic [14:0]         r_h;
    logic [15:0]         r_w;
    logic [N_W-1:0]      r_nseg;
    logic signed [19:0]  r_s16;
    logic signed [19:0]  r_e16;
    logic signed [19:0]  r_p;

    // Even split of the width: w = qw * n + rw, walked Bresenham-style.
    logic [15:0]         r_qw;
    logic [N_W-1:0]      r_rw;
    logic [15:0]         r_acc_q;
    logic [N_W-1:0]      r_acc_r;
    logic [N_W-1:0]      r_idx;

    // Current segment.
    logic signed [16:0]  r_sx;
    logic [15:0]         r_sw;
    logic signed [21:0]  r_d;
    logic signed [22:0]  r_num;
    logic [spgf_pkg::Q_W-1:0] r_q;

    spgf_pkg::t_out      r_out;
    logic                r_out_valid;

    logic [31:0]         rim_colour;
    logic [31:0]         apex_colour;
    spgf_pkg::t_div_req  div_req;
    spgf_pkg::t_div_rsp  div_rsp;
    spgf_pkg::t_mix_req  mix_req;
    spgf_pkg::t_mix_rsp  mix_rsp;

    logic                in_acc;
    logic                out_acc;

    // Set-up arithmetic on the captured request.
    logic                empty_req;
    logic                w_neg;
    logic [15:0]         w_abs;
    logic signed [16:0]  x_adj;
    logic                many_segs;
    logic [8:0]          w_small;
    logic [18:0]         ceil_prod;
    logic [N_W-1:0]      nseg;
    logic signed [19:0]  s16;
    logic signed [19:0]  e16;
    logic signed [19:0]  p_clamp;

    // Segment boundary step.
    logic [N_W:0]        sum_r;
    logic                carry;
    logic [15:0]         sw;
    logic signed [16:0]  sx;

    // Quality set-up.
    logic signed [21:0]  mid;
    logic signed [21:0]  p_ext;
    logic                on_rise;
    logic signed [21:0]  d_val;
    logic signed [22:0]  num_val;
    logic                d_le0;
    logic                num_le0;
    logic                num_ge_d;
    logic                need_div;

    logic                is_last;

    assign in_acc  = i_in_valid & ~o_in_stall;
    assign out_acc = r_out_valid & ~i_out_stall;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    spgf_apb u_apb (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_rim_colour  (rim_colour),
        .o_apex_colour (apex_colour)
    );

    spgf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    spgf_mix u_mix (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (mix_req),
        .i_rim_colour  (rim_colour),
        .i_apex_colour (apex_colour),
        .o_rsp         (mix_rsp)
    );

    // A rectangle with no width or no positive height draws nothing. A
    // negative width moves the left edge to x + w and uses the magnitude.
    assign empty_req = (r_req.rect_w == 16'sd0) | r_req.rect_h[15] |
                       (r_req.rect_h == 16'sd0);
    assign w_neg     = r_req.rect_w[15];
    assign w_abs     = w_neg ? 16'(-r_req.rect_w) : r_req.rect_w;
    assign x_adj     = w_neg ? 17'(r_req.rect_x) + 17'(r_req.rect_w)
                             : 17'(r_req.rect_x);

    // Segment count: ceil(w/6) through a reciprocal multiply, which is exact
    // for the small widths where the count stays under the maximum.
    assign many_segs = (17'(w_abs) > 17'(SEG_LIM));
    assign w_small   = w_abs[8:0] + 9'd5;
    assign ceil_prod = 19'(w_small) * 19'(spgf_pkg::RECIP_SIX);
    assign nseg      = many_segs ? N_W'(MAX_SEGMENTS)
                                 : N_W'(ceil_prod[18:spgf_pkg::RECIP_SIX_SHIFT]);

    // The band in sixteenths of a pixel, and the peak clamped into it. With a
    // reversed band the lower clamp wins, as the order of tests dictates.
    assign s16     = {r_req.band_start, 4'h0};
    assign e16     = {r_req.band_end, 4'h0};
    assign p_clamp = (r_req.peak_pos < s16) ? s16 :
                     (r_req.peak_pos > e16) ? e16 : r_req.peak_pos;

    // Next boundary: advance the quotient and fold the remainder back.
    assign sum_r = {1'b0, r_acc_r} + {1'b0, r_rw};
    assign carry = (sum_r >= {1'b0, r_nseg});
    assign sw    = r_qw + 16'(carry);
    assign sx    = r_x + $signed({1'b0, r_acc_q});

    // Midpoint of the segment in sixteenths, then the rising or falling side
    // of the triangle depending on where it lies against the peak.
    assign mid     = $signed({r_sx[16], r_sx, 4'h0}) + $signed({3'b000, r_sw, 3'b000});
    assign p_ext   = 22'(r_p);
    assign on_rise = (mid <= p_ext);
    assign d_val   = on_rise ? 22'(r_p) - 22'(r_s16) : 22'(r_e16) - 22'(r_p);
    assign num_val = on_rise ? 23'(mid) - 23'(r_s16) : 23'(r_e16) - 23'(mid);

    // A flat side gives full quality, and so does a midpoint at or past the
    // far end of its side; a midpoint outside the side gives none.
    assign d_le0    = r_d[21] | (r_d == 22'sd0);
    assign num_le0  = r_num[22] | (r_num == 23'sd0);
    assign num_ge_d = (r_num >= 23'(r_d));
    assign need_div = ~(d_le0 | num_ge_d) & ~num_le0;

    assign is_last = (r_idx == r_nseg - N_W'(1));

    // The divider is shared: once per rectangle for the even split of the
    // width, then for num * 65536 / d on each segment that needs a true
    // division, where num < d so the quotient needs only sixteen bits.
    always_comb begin
        div_req = '0;
        if (r_state == ST_WSTART) begin
            div_req.start    = 1'b1;
            div_req.dividend = r_w;
            div_req.divisor  = spgf_pkg::DIVR_W'(r_nseg);
        end else if ((r_state == ST_SEGC) && need_div) begin
            div_req.start    = 1'b1;
            div_req.rem_init = r_num[spgf_pkg::DIVR_W-1:0];
            div_req.divisor  = r_d[spgf_pkg::DIVR_W-1:0];
        end
    end

    assign mix_req.start = (r_state == ST_MIXS);
    assign mix_req.q     = r_q;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_state <= empty_req ? ST_IDLE : ST_WSTART;
                end
                ST_WSTART: begin
                    r_state <= ST_DIVW;
                end
                ST_DIVW: begin
                    if (div_rsp.done) begin
                        r_state <= ST_SEGA;
                    end
                end
                ST_SEGA: begin
                    r_state <= ST_SEGB;
                end
                ST_SEGB: begin
                    r_state <= ST_SEGC;
                end
                ST_SEGC: begin
                    r_state <= need_div ? ST_DIVQ : ST_MIXS;
                end
                ST_DIVQ: begin
                    if (div_rsp.done) begin
                        r_state <= ST_MIXS;
                    end
                end
                ST_MIXS: begin
                    r_state <= ST_MIX;
                end
                ST_MIX: begin
                    if (mix_rsp.done) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_acc) begin
                        r_out_valid <= 1'b0;
                        r_state     <= r_out.last_segment ? ST_IDLE : ST_SEGA;
                    end
                end
                default: begin
                    r_state     <= ST_IDLE;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= i_in_data;
        end
        if (r_state == ST_PREP) begin
            r_x    <= x_adj;
            r_y    <= r_req.rect_y;
            r_h    <= r_req.rect_h[14:0];
            r_w    <= w_abs;
            r_nseg <= nseg;
            r_s16  <= s16;
            r_e16  <= e16;
            r_p    <= p_clamp;
        end
        if ((r_state == ST_DIVW) && div_rsp.done) begin
            r_qw    <= div_rsp.quot;
            r_rw    <= div_rsp.rem[N_W-1:0];
            r_acc_q <= '0;
            r_acc_r <= '0;
            r_idx   <= '0;
        end
        if (r_state == ST_SEGA) begin
            r_sx    <= sx;
            r_sw    <= sw;
            r_acc_q <= r_acc_q + sw;
            r_acc_r <= carry ? N_W'(sum_r - {1'b0, r_nseg}) : sum_r[N_W-1:0];
        end
        if (r_state == ST_SEGB) begin
            r_d   <= d_val;
            r_num <= num_val;
        end
        if (r_state == ST_SEGC) begin
            r_q <= (d_le0 | num_ge_d) ? spgf_pkg::Q_ONE : '0;
        end
        if ((r_state == ST_DIVQ) && div_rsp.done) begin
            r_q <= spgf_pkg::Q_W'(div_rsp.quot);
        end
        if ((r_state == ST_MIX) && mix_rsp.done) begin
            r_out.seg_x        <= r_sx;
            r_out.seg_y        <= r_y;
            r_out.seg_width    <= r_sw;
            r_out.seg_height   <= r_h;
            r_out.seg_color    <= mix_rsp.color;
            r_out.last_segment <= is_last;
        end
        if ((r_state == ST_OUT) && out_acc) begin
            r_idx <= r_idx + N_W'(1);
        end
    end

endmodule

// ===== verif/segmented_peak_gradient_fill_checker.sv =====
// Checker for the segmented peak gradient fill: follows the colour registers,
// works out the segments of every accepted rectangle and compares them with
// the output transactions. Depends on spgf_pkg.
module segmented_peak_gradient_fill_checker
    import spgf_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in               i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out              i_out_data,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    input  logic              i_pready,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] outer_colour;
    logic [31:0] peak_colour;
    t_out        expected_segs[$];

    // Each byte moves from the band-edge colour towards the peak colour by frac/65536.
    function automatic logic [31:0] blend_colour(logic [31:0] from_c, logic [31:0] to_c,
                                                 longint frac);
        logic [31:0] mixed;
        longint      a, b, v;
        int          k;
        mixed = '0;
        for (k = 0; k < 4; k++) begin
            a = from_c[8*k +: 8];
            b = to_c[8*k +: 8];
            v = a * 65536 + (b - a) * frac + 32768;
            mixed[8*k +: 8] = v[23:16];
        end
        return mixed;
    endfunction

    // Cuts one rectangle into its segments and queues them in output order.
    function automatic void predict_segments(t_in rect);
        longint x, w, h, peak, band_lo, band_hi, count, i;
        longint sx, ex, sw, mid, span, num, q, f;
        t_out   seg;
        x       = $signed(rect.rect_x);
        w       = $signed(rect.rect_w);
        h       = $signed(rect.rect_h);
        peak    = $signed(rect.peak_pos);
        band_lo = longint'($signed(rect.band_start)) * 16;
        band_hi = longint'($signed(rect.band_end)) * 16;
        if (w == 0 || h <= 0)
            return;
        if (w < 0) begin
            x = x + w;
            w = -w;
        end
        count = (w + 5) / 6;
        if (count > MAX_SEGMENTS)
            count = MAX_SEGMENTS;
        if (count > w)
            count = w;
        if (count < 1)
            count = 1;
        // The lower bound wins when the band is reversed.
        if (peak < band_lo)
            peak = band_lo;
        else if (peak > band_hi)
            peak = band_hi;
        for (i = 0; i < count; i++) begin
            sx  = x + (w * i) / count;
            ex  = x + (w * (i + 1)) / count;
            sw  = ex - sx;
            mid = sx * 16 + sw * 8;
            if (mid <= peak) begin
                span = peak - band_lo;
                num  = mid - band_lo;
            end else begin
                span = band_hi - peak;
                num  = band_hi - mid;
            end
            if (span <= 0) begin
                q = 65536;
            end else begin
                if (num < 0)
                    num = 0;
                if (num > span)
                    num = span;
                q = (num * 65536) / span;
            end
            f = (q * 7 + 5) / 10;
            if (f > 65536)
                f = 65536;
            seg.seg_x        = sx[16:0];
            seg.seg_y        = rect.rect_y;
            seg.seg_width    = sw[15:0];
            seg.seg_height   = h[14:0];
            seg.seg_color    = blend_colour(outer_colour, peak_colour, f);
            seg.last_segment = (i == count - 1);
            expected_segs.push_back(seg);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want, got;
        if (!i_rst_n) begin
            outer_colour = COLOR_RESET;
            peak_colour  = COLOR_RESET;
            expected_segs.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[2])
                    REG_EDGE: outer_colour = i_pwdata;
                    REG_PEAK: peak_colour = i_pwdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                predict_segments(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (expected_segs.size() == 0) begin
                    $error("unexpected segment: seg_x %0d, seg_width %0d",
                           got.seg_x, got.seg_width);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_segs.pop_front();
                    if (got.seg_x !== want.seg_x) begin
                        $error("seg_x: expected %0d, got %0d", want.seg_x, got.seg_x);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.seg_y !== want.seg_y) begin
                        $error("seg_y: expected %0d, got %0d", want.seg_y, got.seg_y);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.seg_width !== want.seg_width) begin
                        $error("seg_width: expected %0d, got %0d",
                               want.seg_width, got.seg_width);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.seg_height !== want.seg_height) begin
                        $error("seg_height: expected %0d, got %0d",
                               want.seg_height, got.seg_height);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.seg_color !== want.seg_color) begin
                        $error("seg_color: expected %h, got %h",
                               want.seg_color, got.seg_color);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.last_segment !== want.last_segment) begin
                        $error("last_segment: expected %0d, got %0d",
                               want.last_segment, got.last_segment);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = expected_segs.size();
    end

endmodule

// ===== verif/segmented_peak_gradient_fill_test.sv =====
// Top of the segmented peak gradient fill testbench: clock, reset, stimulus
// and verdict. Depends on spgf_pkg, the block itself and
// segmented_peak_gradient_fill_checker.
module segmented_peak_gradient_fill_test;
    timeunit 1ns;
    timeprecision 1ps;

    import spgf_pkg::*;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} t_stall_mode;

    // Every input of the block starts at a known value.
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    t_in               in_data   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out              out_data;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [APB_AW-1:0] paddr     = '0;
    logic [31:0]       pwdata    = '0;
    logic [31:0]       prdata;
    logic              pready;
    int                fail_count;
    int                pending;

    // Handshake between the stimulus and the output stall process for the
    // one long hold-off of the run.
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;

    segmented_peak_gradient_fill #(
        .MAX_SEGMENTS(64)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    segmented_peak_gradient_fill_checker #(
        .MAX_SEGMENTS(64)
    ) i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Watchdog. The slowest legal run, with every rectangle giving 64
    // segments and each one held up by the output stall, stays well
    // inside this.
    initial begin
        #100ms;
        $display("segmented_peak_gradient_fill_test NOT OK");
        $finish;
    end

    // The output side stalls in stretches of random length, each with its
    // own pattern: never, now and then, mostly, or alternating. When
    // the stimulus asks for it, the stall is held high for a long stretch so
    // that the block fills up and has to stall its input.
    initial begin
        t_stall_mode mode;
        int          len;
        int          k;
        wait (rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                repeat (400) begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
                hold_done = 1'b1;
            end else begin
                mode = t_stall_mode'($urandom_range(0, 3));
                len  = $urandom_range(10, 150);
                for (k = 0; k < len && !(hold_req && !hold_done); k++) begin
                    @(posedge clk);
                    case (mode)
                        STALL_NONE:  out_stall <= 1'b0;
                        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                        STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
                        default:     out_stall <= ~out_stall;
                    endcase
                end
            end
        end
    end

    function automatic t_in make_rect(int x, int y, int w, int h, int pk, int bs, int be);
        t_in r;
        r.rect_x     = 16'(x);
        r.rect_y     = 16'(y);
        r.rect_w     = 16'(w);
        r.rect_h     = 16'(h);
        r.peak_pos   = 20'(pk);
        r.band_start = 16'(bs);
        r.band_end   = 16'(be);
        return r;
    endfunction

    // Most rectangles are modest and have a band and a peak near them, so
    // that the colours actually vary across the segments. A few fields are
    // now and then fully random, which brings in huge widths, reversed or
    // distant bands and empty rectangles.
    function automatic t_in random_rect();
        t_in r;
        int  x, y, w, h, span, left, bs, be, pk;
        x = $urandom_range(0, 4000);
        x = x - 2000;
        y = $urandom_range(0, 1000);
        y = y - 500;
        case ($urandom_range(0, 15))
            0:       w = $signed(16'($urandom));
            1, 2:    w = $urandom_range(1, 12);
            default: w = $urandom_range(1, 160);
        endcase
        if ($urandom_range(0, 3) == 0)
            w = -w;
        span = (w < 0) ? -w : w;
        left = (w < 0) ? x - span : x;
        case ($urandom_range(0, 15))
            0:       h = -int'($urandom_range(0, 40));
            1:       h = $signed(16'($urandom));
            default: h = $urandom_range(1, 120);
        endcase
        bs = left - 30 + int'($urandom_range(0, 60));
        be = bs - 10 + int'($urandom_range(0, span + 40));
        case ($urandom_range(0, 7))
            0:       pk = $signed(20'($urandom));
            1:       pk = 16 * bs;
            2:       pk = 16 * be;
            default: pk = 16 * left - 64 + int'($urandom_range(0, 16 * span + 128));
        endcase
        if ($urandom_range(0, 7) == 0)
            x = $signed(16'($urandom));
        if ($urandom_range(0, 3) == 0)
            y = $signed(16'($urandom));
        if ($urandom_range(0, 7) == 0)
            bs = $signed(16'($urandom));
        if ($urandom_range(0, 7) == 0)
            be = $signed(16'($urandom));
        r = make_rect(x, y, w, h, pk, bs, be);
        return r;
    endfunction

    // Offers one rectangle and returns at the clock edge at which the
    // transaction is taken. Valid is left high, so a following call in the
    // same time step keeps it asserted without a gap.
    task automatic send_rect(t_in r);
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Waits until every predicted segment has come out, then a little longer
    // in case a rectangle without segments is still being worked on.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending != 0);
        repeat (100) @(posedge clk);
    endtask

    // Writes both colour registers back to back: a setup phase and an
    // access phase each, with the select held between the two.
    task automatic set_colours(logic [31:0] outer, logic [31:0] peak);
        logic [31:0] value;
        logic        index;
        int          k;
        for (k = 0; k < 2; k++) begin
            index   = (k == 0) ? REG_EDGE : REG_PEAK;
            value   = (k == 0) ? outer : peak;
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {index, 2'b00};
            pwdata  <= value;
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random rectangles in bursts of random length. Some bursts run straight
    // into the next one, others are followed by a gap with valid low.
    task automatic run_phase(int count);
        int sent;
        int burst;
        int b;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            for (b = 0; b < burst && sent < count; b++) begin
                send_rect(random_rect());
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 25)) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
    endtask

    initial begin
        t_in         directed[$];
        logic [31:0] outer_set[5];
        logic [31:0] peak_set[5];
        int          k;

        // A plain rectangle at the reset colours, then the empty cases.
        directed.push_back(make_rect(10, 20, 12, 5, 16 * 16, 10, 22));
        directed.push_back(make_rect(0, 0, 0, 10, 0, 0, 10));
        directed.push_back(make_rect(5, 5, 10, 0, 80, 5, 15));
        // From here on the colours differ per byte in both directions.
        directed.push_back(make_rect(5, 5, 10, -1, 80, 5, 15));
        directed.push_back(make_rect(1, 1, 50, -32768, 80, 0, 50));
        // Single pixel; a band of zero length always gives full quality.
        directed.push_back(make_rect(0, 0, 1, 1, 0, 0, 0));
        // Six pixels make one segment, seven make two; extremes of y and h.
        directed.push_back(make_rect(100, -32768, 6, 32767, 1700, 100, 106));
        directed.push_back(make_rect(100, 32767, 7, 3, 1650, 90, 120));
        directed.push_back(make_rect(0, 0, 5, 10, 40, 0, 5));
        // Negative widths, down to the most negative, which also gives the
        // lowest segment position and pushes the peak to the band start.
        directed.push_back(make_rect(-50, 0, -20, 4, -960, -70, -50));
        directed.push_back(make_rect(-32768, 1, -32768, 2, -524288, -32768, 32767));
        directed.push_back(make_rect(-1, -1, -1, 1, -16, -1, -1));
        // Largest width at the right-hand end, peak clamped to the band end.
        directed.push_back(make_rect(32767, 2, 32767, 2, 524287, -32768, 32767));
        directed.push_back(make_rect(0, 0, 32767, 32767, 0, 0, 0));
        // Reversed band, and a peak lying below the band.
        directed.push_back(make_rect(0, 0, 100, 10, 800, 80, 20));
        directed.push_back(make_rect(0, 0, 100, 10, 0, 200, 300));
        // Exactly 64 segments, and a width that the segment limit cuts down.
        directed.push_back(make_rect(0, 0, 384, 10, 3072, 0, 384));
        directed.push_back(make_rect(0, 0, 390, 10, 1600, 0, 390));
        // Peak between pixels inside a wide band: a true triangle.
        directed.push_back(make_rect(0, 0, 60, 7, 488, 0, 60));

        outer_set = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'h0000_0000, $urandom};
        peak_set  = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'h0000_0000, $urandom};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < directed.size(); k++) begin
            if (k == 3) begin
                in_valid <= 1'b0;
                wait_drained();
                set_colours(32'h00FF_00FF, 32'hFF00_FF00);
            end
            send_rect(directed[k]);
        end
        in_valid <= 1'b0;

        // Each phase starts from an empty block: the sender pauses until all
        // expected segments are out, and only then are the colours changed.
        for (k = 0; k < 5; k++) begin
            wait_drained();
            set_colours(outer_set[k], peak_set[k]);
            // In the second phase the output side holds off for a long time
            // while rectangles keep being offered.
            if (k == 1)
                hold_req = 1'b1;
            run_phase(22);
        end

        wait_drained();
        if (fail_count == 0 && pending == 0)
            $display("segmented_peak_gradient_fill_test OK");
        else
            $display("segmented_peak_gradient_fill_test NOT OK");
        $finish;
    end

endmodule
